// ===== rtl/tcw_pkg.sv =====
`default_nettype none
// ============================================================================
// tcw_pkg
// Shared types, codes and helpers for the text console writer.
// ============================================================================
package tcw_pkg;

  localparam int unsigned CELL_IDX_W = 11;
  localparam int unsigned BYTE_W     = 8;

  localparam logic [1:0] CMD_PUT  = 2'd0;
  localparam logic [1:0] CMD_POST = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;
  localparam logic [1:0] CMD_READ = 2'd3;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [3:0] TAB_STOP   = 4'd8;

  localparam logic [7:0] HEX_DIGIT_BASE = 8'h30;  // '0'
  localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;  // 'A' - 10

  // screen store write source
  typedef enum logic [3:0] {
    W_NONE,
    W_ZERO,
    W_COPY,
    W_BLANK,
    W_CHAR,
    W_SPACE,
    W_ATTR,
    W_POST_HI,
    W_POST_LO
  } wsel_e;

  // screen store read address source
  typedef enum logic [1:0] {
    R_PTR,
    R_CURSOR,
    R_INDEX
  } rsel_e;

  typedef enum logic [2:0] {
    C_HOLD,
    C_INC,
    C_DEC,
    C_SUB_COLS,
    C_LOAD_BASE,
    C_LOAD_IDX
  } cur_op_e;

  typedef enum logic [2:0] {
    P_HOLD,
    P_INC,
    P_COPY_START,
    P_BLANK_START
  } ptr_op_e;

  typedef struct packed {
    wsel_e   wsel;
    rsel_e   rsel;
    cur_op_e cur_op;
    ptr_op_e ptr_op;
    logic    item_ld;
    logic    base_init;
    logic    base_inc;
    logic    cnt_dec;
    logic    scr_set;
    logic    out_ld;
  } tcw_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       is_nl;
    logic       is_tab;
    logic       is_bs;
    logic       cursor_zero;
    logic       at_limit;
    logic       base_past;
    logic       tab_last;
    logic       clear_last;
    logic       copy_last;
    logic       blank_last;
  } tcw_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n;
    n = {4'h0, nib};
    return (nib < 4'd10) ? (HEX_DIGIT_BASE + n) : (HEX_ALPHA_BASE + n);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/text_console_writer_unit.sv =====
`default_nettype none
// ============================================================================
// text_console_writer_unit
// Text screen writer: character/attribute store, cursor, scroll, post code.
// ============================================================================
// Usage:
//   An item is taken at a clock edge with start high and busy low. Its one
//   result appears on cursor_pos_o, read_char_o, read_attr_o and scrolled_o
//   for exactly one cycle, marked by done_o; the receiver cannot stall, and
//   busy is already low in the strobe cycle, so a new item may be started
//   there. text_attribute_i is written whenever text_attribute_we_i is high.
// Sequencing:
//   load cursor and read cell go straight to the result; a post code writes
//   two hex digits into the last two cells; a put writes the cell and steps
//   the cursor; a tab writes spaces to the next tab stop; backspace steps
//   back and blanks that cell; newline scans rows for the next row start.
//   A scroll copies one cell per cycle through the single write port of the store.
// Reset:
//   cursor and strobe clear, attribute returns to 0x07, and a clearing pass
//   zeroes the screen store one cell a cycle with busy high; attribute
//   writes are taken meanwhile.
// ============================================================================
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS    = 80,
  parameter int unsigned ROWS       = 25,
  parameter int unsigned POST_CELLS = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            cmd_i,
  input  wire logic [BYTE_W-1:0]     char_byte_i,
  input  wire logic [CELL_IDX_W-1:0] cell_index_i,
  input  wire logic [BYTE_W-1:0]     post_code_i,
  input  wire logic                  text_attribute_we_i,
  input  wire logic [BYTE_W-1:0]     text_attribute_i,
  output logic                       done_o,
  output logic [CELL_IDX_W-1:0]      cursor_pos_o,
  output logic [BYTE_W-1:0]          read_char_o,
  output logic [BYTE_W-1:0]          read_attr_o,
  output logic                       scrolled_o
);

  tcw_cmd_t  ctl;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .ctl_o   (ctl)
  );

  tcw_datapath #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .POST_CELLS (POST_CELLS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .cmd_i        (cmd_i),
    .char_byte_i  (char_byte_i),
    .cell_index_i (cell_index_i),
    .post_code_i  (post_code_i),
    .attr_we_i    (text_attribute_we_i),
    .attr_i       (text_attribute_i),
    .done_o       (done_o),
    .cursor_pos_o (cursor_pos_o),
    .read_char_o  (read_char_o),
    .read_attr_o  (read_attr_o),
    .scrolled_o   (scrolled_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_load_no_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.item_ld && cmd_i != CMD_PUT) |=> !ctl.scr_set)
    else $error("non-put item started a scroll");
`endif

endmodule
`default_nettype wire

// ===== rtl/tcw_ram.sv =====
`default_nettype none
// ============================================================================
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/tcw_datapath.sv =====
`default_nettype none
// ============================================================================
// tcw_datapath
// Cursor, pointers, item registers, screen store and result registers.
// ============================================================================
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS    = 80,
  parameter int unsigned ROWS       = 25,
  parameter int unsigned POST_CELLS = 2
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tcw_cmd_t              ctl_i,
  output tcw_stat_t                  stat_o,
  input  wire logic [1:0]            cmd_i,
  input  wire logic [BYTE_W-1:0]     char_byte_i,
  input  wire logic [CELL_IDX_W-1:0] cell_index_i,
  input  wire logic [BYTE_W-1:0]     post_code_i,
  input  wire logic                  attr_we_i,
  input  wire logic [BYTE_W-1:0]     attr_i,
  output logic                       done_o,
  output logic [CELL_IDX_W-1:0]      cursor_pos_o,
  output logic [BYTE_W-1:0]          read_char_o,
  output logic [BYTE_W-1:0]          read_attr_o,
  output logic                       scrolled_o
);

  localparam int unsigned CELL_COUNT   = COLUMNS * ROWS;
  localparam int unsigned SCROLL_LIMIT = CELL_COUNT - POST_CELLS;
  localparam int unsigned CW = $clog2(CELL_COUNT + 1);
  localparam int unsigned AW = $clog2(CELL_COUNT);
  localparam int unsigned XW = (CW > CELL_IDX_W) ? CW : CELL_IDX_W;

  localparam logic [CW-1:0] COLS_C      = CW'(COLUMNS);
  localparam logic [CW-1:0] LIMIT_C     = CW'(SCROLL_LIMIT);
  localparam logic [CW-1:0] BLANK_START = CW'(SCROLL_LIMIT - COLUMNS);
  localparam logic [CW-1:0] BLANK_LAST  = CW'(SCROLL_LIMIT - 1);
  localparam logic [CW-1:0] CLEAR_LAST  = CW'(CELL_COUNT - 1);
  localparam logic [CW-1:0] POST_HI_C   = CW'(CELL_COUNT - 2);
  localparam logic [CW-1:0] ONE_C       = CW'(1);

  logic [CW-1:0] cursor_q, cursor_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] base_q;
  logic [3:0]    cnt_q;
  logic [7:0]    attr_q;
  logic          scr_q;
  logic          done_q;

  logic [1:0]            cmd_q;
  logic [BYTE_W-1:0]     char_q;
  logic [CELL_IDX_W-1:0] idx_q;
  logic [BYTE_W-1:0]     code_q;

  logic [CELL_IDX_W-1:0] cpos_q;
  logic [BYTE_W-1:0]     rchar_q, rattr_q;
  logic                  rscr_q;

  logic [XW-1:0] idx_x, cur_x;
  logic          idx_ok;
  logic [CW-1:0] idx_load;

  logic          mem_we;
  logic [CW-1:0] waddr;
  logic [15:0]   wdata;
  logic [CW-1:0] raddr;
  logic [15:0]   rdata;

  assign idx_x    = XW'(idx_q);
  assign cur_x    = XW'(cursor_q);
  assign idx_ok   = idx_x < XW'(CELL_COUNT);
  assign idx_load = idx_ok ? idx_x[CW-1:0] : CLEAR_LAST;

  always_comb begin
    stat_o.cmd         = cmd_q;
    stat_o.is_nl       = char_q == CH_NL;
    stat_o.is_tab      = char_q == CH_TAB;
    stat_o.is_bs       = char_q == CH_BS;
    stat_o.cursor_zero = cursor_q == '0;
    stat_o.at_limit    = cursor_q >= LIMIT_C;
    stat_o.base_past   = base_q > cursor_q;
    stat_o.tab_last    = cnt_q == 4'd1;
    stat_o.clear_last  = ptr_q == CLEAR_LAST;
    stat_o.copy_last   = ptr_q == LIMIT_C;
    stat_o.blank_last  = ptr_q == BLANK_LAST;
  end

  always_comb begin
    case (ctl_i.cur_op)
      C_INC:       cursor_d = cursor_q + ONE_C;
      C_DEC:       cursor_d = cursor_q - ONE_C;
      C_SUB_COLS:  cursor_d = cursor_q - COLS_C;
      C_LOAD_BASE: cursor_d = base_q;
      C_LOAD_IDX:  cursor_d = idx_load;
      default:     cursor_d = cursor_q;
    endcase
  end

  always_comb begin
    case (ctl_i.ptr_op)
      P_INC:         ptr_d = ptr_q + ONE_C;
      P_COPY_START:  ptr_d = COLS_C;
      P_BLANK_START: ptr_d = BLANK_START;
      default:       ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    mem_we = 1'b1;
    waddr  = cursor_q;
    wdata  = '0;
    case (ctl_i.wsel)
      W_ZERO: begin
        waddr = ptr_q;
      end
      W_COPY: begin
        mem_we = ptr_q != COLS_C;
        waddr  = ptr_q - COLS_C - ONE_C;
        wdata  = rdata;
      end
      W_BLANK: begin
        waddr = ptr_q;
        wdata = {attr_q, CH_SPACE};
      end
      W_CHAR: begin
        wdata = {attr_q, char_q};
      end
      W_SPACE: begin
        wdata = {attr_q, CH_SPACE};
      end
      W_ATTR: begin
        wdata = {attr_q, rdata[7:0]};
      end
      W_POST_HI: begin
        waddr = POST_HI_C;
        wdata = {attr_q, hex_char(code_q[7:4])};
      end
      W_POST_LO: begin
        waddr = CLEAR_LAST;
        wdata = {attr_q, hex_char(code_q[3:0])};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (ctl_i.rsel)
      R_CURSOR: raddr = cursor_q;
      R_INDEX:  raddr = idx_x[CW-1:0];
      default:  raddr = ptr_q;
    endcase
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      ptr_q    <= '0;
      attr_q   <= ATTR_RESET;
      scr_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      cursor_q <= cursor_d;
      ptr_q    <= ptr_d;
      done_q   <= ctl_i.out_ld;
      if (attr_we_i) begin
        attr_q <= attr_i;
      end
      if (ctl_i.item_ld) begin
        scr_q <= 1'b0;
      end else if (ctl_i.scr_set) begin
        scr_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.item_ld) begin
      cmd_q  <= cmd_i;
      char_q <= char_byte_i;
      idx_q  <= cell_index_i;
      code_q <= post_code_i;
      cnt_q  <= TAB_STOP - {1'b0, cursor_q[2:0]};
    end else if (ctl_i.cnt_dec) begin
      cnt_q <= cnt_q - 4'd1;
    end
    if (ctl_i.base_init) begin
      base_q <= COLS_C;
    end else if (ctl_i.base_inc) begin
      base_q <= base_q + COLS_C;
    end
    if (ctl_i.out_ld) begin
      cpos_q  <= cur_x[CELL_IDX_W-1:0];
      rscr_q  <= scr_q;
      rchar_q <= (cmd_q == CMD_READ && idx_ok) ? rdata[7:0]  : '0;
      rattr_q <= (cmd_q == CMD_READ && idx_ok) ? rdata[15:8] : '0;
    end
  end

  assign done_o       = done_q;
  assign cursor_pos_o = cpos_q;
  assign read_char_o  = rchar_q;
  assign read_attr_o  = rattr_q;
  assign scrolled_o   = rscr_q;

endmodule
`default_nettype wire

// ===== rtl/tcw_ctrl.sv =====
`default_nettype none
// ============================================================================
// tcw_ctrl
// Sequencer for clear pass, puts, scrolls, post codes, loads and reads.
// ============================================================================
module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire tcw_stat_t stat_i,
  output tcw_cmd_t       ctl_o
);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_START   = 4'd2;
  localparam logic [3:0] ST_PUT_WR  = 4'd3;
  localparam logic [3:0] ST_CHECK   = 4'd4;
  localparam logic [3:0] ST_COPY    = 4'd5;
  localparam logic [3:0] ST_BLANK   = 4'd6;
  localparam logic [3:0] ST_ATTR_RD = 4'd7;
  localparam logic [3:0] ST_ATTR_WR = 4'd8;
  localparam logic [3:0] ST_NL_SCAN = 4'd9;
  localparam logic [3:0] ST_POST_LO = 4'd10;
  localparam logic [3:0] ST_DONE    = 4'd11;

  logic [3:0] state_q, state_d;
  logic       second_q, second_d;

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    ctl_o    = '{wsel: W_NONE, rsel: R_PTR, cur_op: C_HOLD, ptr_op: P_HOLD,
                 default: 1'b0};
    case (state_q)
      ST_CLEAR: begin
        ctl_o.wsel   = W_ZERO;
        ctl_o.ptr_op = P_INC;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.item_ld = 1'b1;
          second_d      = 1'b0;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        ctl_o.rsel = R_INDEX;
        case (stat_i.cmd)
          CMD_PUT: begin
            if (stat_i.is_nl) begin
              ctl_o.base_init = 1'b1;
              state_d         = ST_NL_SCAN;
            end else begin
              if (stat_i.is_bs && !stat_i.cursor_zero) begin
                ctl_o.cur_op = C_DEC;
              end
              state_d = ST_PUT_WR;
            end
          end
          CMD_POST: begin
            ctl_o.wsel = W_POST_HI;
            state_d    = ST_POST_LO;
          end
          CMD_LOAD: begin
            ctl_o.cur_op = C_LOAD_IDX;
            state_d      = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_PUT_WR: begin
        ctl_o.wsel   = (stat_i.is_tab || stat_i.is_bs) ? W_SPACE : W_CHAR;
        ctl_o.cur_op = C_INC;
        state_d      = ST_CHECK;
      end
      ST_CHECK: begin
        ctl_o.rsel = R_CURSOR;
        if (stat_i.at_limit) begin
          ctl_o.ptr_op = P_COPY_START;
          state_d      = ST_COPY;
        end else begin
          state_d = ST_ATTR_WR;
        end
      end
      ST_COPY: begin
        ctl_o.wsel   = W_COPY;
        ctl_o.rsel   = R_PTR;
        ctl_o.ptr_op = P_INC;
        if (stat_i.copy_last) begin
          ctl_o.ptr_op = P_BLANK_START;
          state_d      = ST_BLANK;
        end
      end
      ST_BLANK: begin
        ctl_o.wsel   = W_BLANK;
        ctl_o.ptr_op = P_INC;
        if (stat_i.blank_last) begin
          ctl_o.cur_op  = C_SUB_COLS;
          ctl_o.scr_set = 1'b1;
          state_d       = ST_ATTR_RD;
        end
      end
      ST_ATTR_RD: begin
        ctl_o.rsel = R_CURSOR;
        state_d    = ST_ATTR_WR;
      end
      ST_ATTR_WR: begin
        ctl_o.wsel = W_ATTR;
        if (stat_i.is_tab) begin
          if (stat_i.tab_last) begin
            state_d = ST_DONE;
          end else begin
            ctl_o.cnt_dec = 1'b1;
            state_d       = ST_PUT_WR;
          end
        end else if (stat_i.is_bs && !second_q) begin
          ctl_o.cur_op = C_DEC;
          second_d     = 1'b1;
          state_d      = ST_CHECK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_NL_SCAN: begin
        if (stat_i.base_past) begin
          ctl_o.cur_op = C_LOAD_BASE;
          state_d      = ST_CHECK;
        end else begin
          ctl_o.base_inc = 1'b1;
        end
      end
      ST_POST_LO: begin
        ctl_o.wsel = W_POST_LO;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        ctl_o.out_ld = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;

endmodule
`default_nettype wire
